/* src/grid_min_cost_path_macros.svh */
// shared assertion macros
`ifndef GRID_MIN_COST_PATH_MACROS_SVH
`define GRID_MIN_COST_PATH_MACROS_SVH

// same-cycle implication
`define GCP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("gcp assertion failed");

// next-cycle implication
`define GCP_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gcp assertion failed");

`endif

/* src/gcp_pkg.sv */
`default_nettype none
package gcp_pkg;
	localparam int COST_W = 24;
	localparam int CELL_W = 16;
	localparam int MAX_COLS = 64;
	localparam int IDX_W = $clog2(MAX_COLS);

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam cost_t COST_MAX = {COST_W{1'b1}};
	localparam idx_t LAST_ROW_RST = IDX_W'(3);
	localparam idx_t LAST_COL_RST = IDX_W'(3);

	typedef enum logic [0:0] {
		REG_LAST_ROW = 1'b0,
		REG_LAST_COL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
	} rs_req_t;
endpackage
`default_nettype wire

/* src/gcp_row_store.sv */
`default_nettype none
module gcp_row_store (
	input  wire             clk,
	input  gcp_pkg::rs_req_t req,
	input  gcp_pkg::cost_t  wr_data,
	output gcp_pkg::cost_t  rd_data
);
	import gcp_pkg::*;

	cost_t mem [MAX_COLS];
	cost_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

/* src/grid_min_cost_path.sv */
// channel   dir  fields (lsb first)              beat taken when
// s_axis    in   tdata: cell_cost[15:0]          s_axis_tvalid & s_axis_tready
// m_axis    out  tdata: path_cost[23:0]          m_axis_tvalid & m_axis_tready
//                tlast: is_target
// cfg       in   cfg_idx, cfg_data[5:0]          cfg_we
//
// One cell per cycle unless stalled; stage 1 holds a cell, out_cost_q its result.
// The row store is read when a cell is taken and written as the result moves to the
// output register; a write to the same column at the read edge is bypassed.
// Reset: last_row = last_col = 3, position (0,0), left total 0; row store not cleared.
// A stalled output holds one result and one cell in flight, then drops s_axis_tready.
`default_nettype none
module grid_min_cost_path (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  [15:0]       s_axis_tdata,   // cell_cost[15:0]
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [23:0]       m_axis_tdata,   // path_cost[23:0]
	output logic              m_axis_tlast,   // is_target
	input  wire               cfg_we,
	input  gcp_pkg::cfg_reg_t cfg_idx,
	input  wire  [5:0]        cfg_data
);
	import gcp_pkg::*;

	idx_t last_row_q, last_col_q;
	idx_t row_q, col_q;
	cost_t left_q;

	logic v_s1_q;
	cell_t cost_s1;
	idx_t col_s1;
	logic row0_s1, col0_s1, target_s1;
	logic byp_hit_s1;
	cost_t byp_s1;

	logic out_v_q;
	cost_t out_cost_q;
	logic out_last_q;

	logic s1_move, accept;
	cost_t up, best, base, total, rd_data;
	logic [COST_W:0] sum;
	rs_req_t rs_req;

	assign s1_move = v_s1_q && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1_q || s1_move;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		up = byp_hit_s1 ? byp_s1 : rd_data;
		best = (up < left_q) ? up : left_q;
		if (row0_s1 && col0_s1) begin
			base = '0;
		end else if (row0_s1) begin
			base = left_q;
		end else if (col0_s1) begin
			base = up;
		end else begin
			base = best;
		end
		sum = {1'b0, base} + {{(COST_W+1-CELL_W){1'b0}}, cost_s1};
		total = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
	end

	always_comb begin
		rs_req.rd_en = accept;
		rs_req.rd_addr = col_q;
		rs_req.wr_en = s1_move;
		rs_req.wr_addr = col_s1;
	end

	gcp_row_store u_row_store (
		.clk     (clk),
		.req     (rs_req),
		.wr_data (total),
		.rd_data (rd_data)
	);

	// position, limits and left total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= LAST_ROW_RST;
			last_col_q <= LAST_COL_RST;
			row_q <= '0;
			col_q <= '0;
			left_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LAST_ROW: last_row_q <= cfg_data;
				REG_LAST_COL: last_col_q <= cfg_data;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
			left_q <= '0;
		end else begin
			if (s1_move) begin
				left_q <= total;
			end
			if (accept) begin
				if (col_q >= last_col_q) begin
					col_q <= '0;
					row_q <= (row_q >= last_row_q) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1_q <= 1'b1;
			end else if (s1_move) begin
				v_s1_q <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cost_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			row0_s1 <= (row_q == '0);
			col0_s1 <= (col_q == '0);
			target_s1 <= (row_q == last_row_q) && (col_q == last_col_q);
			byp_hit_s1 <= s1_move && (col_s1 == col_q);
			byp_s1 <= total;
		end
		if (s1_move) begin
			out_cost_q <= total;
			out_last_q <= target_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_cost_q;
	assign m_axis_tlast = out_last_q;
endmodule
`default_nettype wire

/* src/gcp_checker.sv */
`default_nettype none
`include "grid_min_cost_path_macros.svh"
module gcp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata,
	input wire        m_axis_tlast
);
	logic [1:0] pend_q;
	logic in_beat, out_beat;
	logic out_wait;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign out_wait = m_axis_tvalid && !m_axis_tready;

	// cells taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	`GCP_ASSERT_NXT(a_out_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))
	`GCP_ASSERT_IMP(a_no_phantom, clk, arst_n, pend_q == 2'd0, !m_axis_tvalid)
	`GCP_ASSERT_IMP(a_full_stall, clk, arst_n, (pend_q == 2'd2) && !m_axis_tready, !s_axis_tready)
	`GCP_ASSERT_IMP(a_bound, clk, arst_n, 1'b1, pend_q != 2'd3)
endmodule

bind grid_min_cost_path gcp_checker u_gcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
